>>> rtl/core/mmp_pkg.sv
// Shared types and constants for the minimap marker projection core.
// Holds the quarter-sine polynomial coefficients, register indexes and stage payloads.
// No dependencies.
package mmp_pkg;

  localparam logic [30:0] COEF_C1 = 31'd1686629713;
  localparam logic [30:0] COEF_C3 = 31'd693598668;
  localparam logic [30:0] COEF_C5 = 31'd85569300;
  localparam logic [30:0] COEF_C7 = 31'd5026994;
  localparam logic [30:0] COEF_C9 = 31'd172273;

  localparam int SUM_W  = 49;  // |v|^2 sum after normalization
  localparam int ROOT_W = 25;  // integer square root of the sum
  localparam int NUM_W  = 42;  // |v| * radius
  localparam int QUO_W  = 18;  // clamped magnitude, never above the radius

  typedef enum logic [1:0] {
    REG_MAP_SCALE     = 2'd0,
    REG_MAP_HALF_SIZE = 2'd1,
    REG_MAP_OFFSET    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
  } delta_t;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic        outside;
    logic [23:0] nx;
    logic [23:0] ny;
  } vec_t;

  // coefficient subtracted at Horner stage 3..5 of the sine pipe
  function automatic logic [30:0] horner_coef(input int stage);
    logic [30:0] c;
    case (stage)
      3:       c = COEF_C5;
      4:       c = COEF_C3;
      default: c = COEF_C1;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/mmp_sine.sv
// Pipelined Q1.15 sine and cosine of a 16-bit angle, seven stages.
// Carries the world delta alongside. Depends on mmp_pkg.
module mmp_sine
  import mmp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  delta_t             delta_i,
  input  logic [15:0]        angle_i,
  output logic               vld_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o,
  output delta_t             delta_o
);

  localparam int NST = 7;

  logic [NST-1:0]     vld_q;
  delta_t             delta_q [NST];
  logic [15:0]        ang     [2];
  logic [14:0]        u_d     [2];
  logic               neg_d   [2];
  logic [14:0]        u_q     [2][6];
  logic               neg_q   [2][6];
  logic [28:0]        t2_q    [2][1:4];
  logic [30:0]        p_q     [2][2:5];
  logic [45:0]        fin     [2];
  logic [16:0]        s_raw   [2];
  logic [14:0]        s_sat   [2];
  logic signed [15:0] s_q     [2];

  assign ang[0] = angle_i;
  assign ang[1] = 16'(angle_i + 16'd16384);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      u_d[l]   = ang[l][14] ? 15'(15'd16384 - 15'(ang[l][13:0])) : 15'(ang[l][13:0]);
      neg_d[l] = ang[l][15];
      fin[l]   = 46'(u_q[l][5]) * 46'(p_q[l][5]) + (46'd1 << 28);
      s_raw[l] = fin[l][45:29];
      s_sat[l] = (s_raw[l] > 17'd32767) ? 15'h7FFF : s_raw[l][14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        u_q[l][0]   <= u_d[l];
        neg_q[l][0] <= neg_d[l];
        for (int i = 1; i < 6; i++) begin
          u_q[l][i]   <= u_q[l][i-1];
          neg_q[l][i] <= neg_q[l][i-1];
        end
        t2_q[l][1] <= 29'(u_q[l][0]) * 29'(u_q[l][0]);
        for (int i = 2; i < 5; i++) begin
          t2_q[l][i] <= t2_q[l][i-1];
        end
        p_q[l][2] <= COEF_C7 - 31'((60'(t2_q[l][1]) * 60'(COEF_C9)) >> 28);
        for (int k = 3; k < 6; k++) begin
          p_q[l][k] <= horner_coef(k) - 31'((60'(t2_q[l][k-1]) * 60'(p_q[l][k-1])) >> 28);
        end
        s_q[l] <= neg_q[l][5] ? -$signed({1'b0, s_sat[l]}) : $signed({1'b0, s_sat[l]});
      end
      delta_q[0] <= delta_i;
      for (int i = 1; i < NST; i++) begin
        delta_q[i] <= delta_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  assign vld_o   = vld_q[NST-1];
  assign sin_o   = s_q[0];
  assign cos_o   = s_q[1];
  assign delta_o = delta_q[NST-1];

endmodule

>>> rtl/core/mmp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Carries the vector payload alongside. Depends on mmp_pkg.
module mmp_isqrt
  import mmp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [SUM_W-1:0]  n_i,
  input  vec_t              vec_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output vec_t              vec_o
);

  localparam int NST = ROOT_W;

  logic [NST-1:0]   vld_q;
  logic [SUM_W-1:0] n_q   [NST];
  logic [SUM_W:0]   res_q [NST];
  vec_t             vec_q [NST];
  logic [SUM_W-1:0] n_p   [NST];
  logic [SUM_W:0]   res_p [NST];
  logic [SUM_W:0]   bitv  [NST];
  logic [SUM_W:0]   trial [NST];
  logic [SUM_W-1:0] n_d   [NST];
  logic [SUM_W:0]   res_d [NST];

  always_comb begin
    for (int s = 0; s < NST; s++) begin
      n_p[s]   = (s == 0) ? n_i : n_q[s-1];
      res_p[s] = (s == 0) ? '0 : res_q[s-1];
      bitv[s]  = (SUM_W+1)'(1) << (2 * (NST - 1 - s));
      trial[s] = res_p[s] + bitv[s];
      if ({1'b0, n_p[s]} >= trial[s]) begin
        n_d[s]   = n_p[s] - trial[s][SUM_W-1:0];
        res_d[s] = (res_p[s] >> 1) + bitv[s];
      end else begin
        n_d[s]   = n_p[s];
        res_d[s] = res_p[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NST; s++) begin
        n_q[s]   <= n_d[s];
        res_q[s] <= res_d[s];
        vec_q[s] <= (s == 0) ? vec_i : vec_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign root_o = res_q[NST-1][ROOT_W-1:0];
  assign vec_o  = vec_q[NST-1];

endmodule

>>> rtl/core/mmp_div.sv
// Pipelined two-lane restoring divider, one quotient bit per stage.
// Both lanes share the divisor; carries the vector payload. Depends on mmp_pkg.
module mmp_div
  import mmp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [1:0][NUM_W-1:0]      num_i,
  input  logic [ROOT_W-1:0]          den_i,
  input  vec_t                       vec_i,
  output logic                       vld_o,
  output logic [1:0][QUO_W-1:0]      quo_o,
  output vec_t                       vec_o
);

  localparam int NST = QUO_W;

  logic [NST-1:0]    vld_q;
  logic [ROOT_W-1:0] rem_q [NST][2];
  logic [NUM_W-1:0]  num_q [NST][2];
  logic [QUO_W-1:0]  quo_q [NST][2];
  logic [ROOT_W-1:0] den_q [NST];
  vec_t              vec_q [NST];
  logic [ROOT_W-1:0] rem_p [NST][2];
  logic [NUM_W-1:0]  num_p [NST][2];
  logic [QUO_W-1:0]  quo_p [NST][2];
  logic [ROOT_W-1:0] den_p [NST];
  logic [ROOT_W:0]   t     [NST][2];
  logic [ROOT_W-1:0] rem_d [NST][2];
  logic [QUO_W-1:0]  quo_d [NST][2];

  always_comb begin
    for (int s = 0; s < NST; s++) begin
      den_p[s] = (s == 0) ? den_i : den_q[s-1];
      for (int l = 0; l < 2; l++) begin
        rem_p[s][l] = (s == 0) ? ROOT_W'(num_i[l] >> QUO_W) : rem_q[s-1][l];
        num_p[s][l] = (s == 0) ? num_i[l] : num_q[s-1][l];
        quo_p[s][l] = (s == 0) ? '0 : quo_q[s-1][l];
        t[s][l]     = {rem_p[s][l], num_p[s][l][QUO_W-1-s]};
        if (t[s][l] >= {1'b0, den_p[s]}) begin
          rem_d[s][l] = ROOT_W'(t[s][l] - {1'b0, den_p[s]});
          quo_d[s][l] = quo_p[s][l] | (QUO_W'(1) << (QUO_W - 1 - s));
        end else begin
          rem_d[s][l] = t[s][l][ROOT_W-1:0];
          quo_d[s][l] = quo_p[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NST; s++) begin
        den_q[s] <= den_p[s];
        vec_q[s] <= (s == 0) ? vec_i : vec_q[s-1];
        for (int l = 0; l < 2; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          num_q[s][l] <= num_p[s][l];
          quo_q[s][l] <= quo_d[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  assign vld_o    = vld_q[NST-1];
  assign quo_o[0] = quo_q[NST-1][0];
  assign quo_o[1] = quo_q[NST-1][1];
  assign vec_o    = vec_q[NST-1];

endmodule

>>> rtl/core/minimap_marker_projection_core.sv
// Minimap marker projection core: rotate, scale, circular clamp and round.
// Top level; instantiates mmp_sine, mmp_isqrt and mmp_div. Depends on mmp_pkg.
//
// Usage:
//   s_axis carries one marker request per transfer: target and player world
//   position plus player yaw. m_axis returns one marker per request, in order:
//   rounded widget X/Y in pixels and a flag in tuser set when the point was
//   pulled onto the clamp circle.
//   cfg_we_i writes map_scale, map_half_size or map_offset by index; write
//   only while no request is in flight.
// Stages: 7 sine stages, 6 rotate/scale/magnitude stages, 25 square-root
//   stages, 1 numerator stage, 18 divider stages, 1 output register.
// Throughput: one transfer per cycle unless stalled; every stage holds one item.
// Reset: all stage valid bits clear, registers return to their defaults
//   (scale 256/1500, half size 128, offset -130).
// Stall: when the output register is full and m_axis_tready is low the whole
//   pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
module minimap_marker_projection_core
  import mmp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_x[23:0], target_y[47:24], player_x[71:48], player_y[95:72], player_yaw[111:96]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // marker_x[11:0], marker_y[23:12]
  output logic [23:0]  m_axis_tdata,
  // was_clamped[0]
  output logic [0:0]   m_axis_tuser
);

  logic               pipe_en;
  logic [23:0]        scale_q;
  logic [9:0]         hs_q;
  logic signed [9:0]  off_q;
  logic [17:0]        rq;
  logic [19:0]        hs_sq;
  logic [35:0]        rq2;

  delta_t             in_delta;
  logic [15:0]        in_angle;

  logic               sn_vld;
  logic signed [15:0] sn, cs;
  delta_t             sn_delta;

  logic               r1_vld_q;
  logic signed [40:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic               r2_vld_q;
  logic signed [41:0] rx_d, ry_d;
  logic signed [33:0] tx_q, ty_q;
  logic               r3_vld_q;
  logic signed [35:0] vx_q, vy_q;
  logic [35:0]        ax_d, ay_d;
  logic [11:0]        hi_d;
  logic [3:0]         sh_d;
  vec_t               vec4_d;
  logic               r4_vld_q, big4_q;
  vec_t               vec4_q;
  logic               r5_vld_q, big5_q;
  logic [47:0]        sqx_q, sqy_q;
  vec_t               vec5_q;
  logic               r6_vld_q;
  logic [48:0]        sum_d;
  logic [48:0]        sum6_q;
  vec_t               vec6_d, vec6_q;

  logic               sq_vld;
  logic [24:0]        root;
  vec_t               vec_sq;

  logic               r7_vld_q;
  logic [1:0][41:0]   num7_q;
  logic [24:0]        den7_q;
  vec_t               vec7_q;

  logic               dv_vld;
  logic [1:0][17:0]   quo;
  vec_t               vec_dv;

  logic signed [12:0] base13;
  logic [23:0]        mag   [2];
  logic signed [24:0] vsel  [2];
  logic signed [26:0] pos   [2];
  logic signed [18:0] rnd   [2];
  logic signed [11:0] sat   [2];
  logic               sgn   [2];
  logic               out_vld_q;
  logic signed [11:0] mx_q, my_q;
  logic               clamp_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 24'd2863312;
      hs_q    <= 10'd128;
      off_q   <= -10'sd130;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAP_SCALE:     scale_q <= cfg_wdata_i;
        REG_MAP_HALF_SIZE: hs_q    <= cfg_wdata_i[9:0];
        REG_MAP_OFFSET:    off_q   <= $signed(cfg_wdata_i[9:0]);
        default: ;
      endcase
    end
  end

  assign rq    = {hs_q, 8'b0};
  assign hs_sq = 20'(hs_q) * 20'(hs_q);
  assign rq2   = {hs_sq, 16'b0};

  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  assign in_delta.dx = 25'($signed(s_axis_tdata[23:0])) - 25'($signed(s_axis_tdata[71:48]));
  assign in_delta.dy = 25'($signed(s_axis_tdata[47:24])) - 25'($signed(s_axis_tdata[95:72]));
  assign in_angle    = 16'(s_axis_tdata[111:96] + 16'd16384);

  mmp_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .vld_i   (s_axis_tvalid),
    .delta_i (in_delta),
    .angle_i (in_angle),
    .vld_o   (sn_vld),
    .sin_o   (sn),
    .cos_o   (cs),
    .delta_o (sn_delta)
  );

  // rotate, scale, normalize
  assign rx_d = 42'(pxc_q) + 42'(pys_q);
  assign ry_d = 42'(pyc_q) - 42'(pxs_q);

  always_comb begin
    ax_d = vx_q[35] ? 36'(-vx_q) : 36'(vx_q);
    ay_d = vy_q[35] ? 36'(-vy_q) : 36'(vy_q);
    hi_d = ax_d[35:24] | ay_d[35:24];
    sh_d = '0;
    for (int i = 0; i < 12; i++) begin
      if (hi_d[i]) begin
        sh_d = 4'(i + 1);
      end
    end
    vec4_d.sx      = vx_q[35];
    vec4_d.sy      = vy_q[35];
    vec4_d.outside = 1'b0;
    vec4_d.nx      = 24'(ax_d >> sh_d);
    vec4_d.ny      = 24'(ay_d >> sh_d);
  end

  assign sum_d = 49'(sqx_q) + 49'(sqy_q);

  always_comb begin
    vec6_d         = vec5_q;
    vec6_d.outside = big5_q || (sum_d > 49'(rq2));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pxc_q  <= 41'(sn_delta.dx) * 41'(cs);
      pys_q  <= 41'(sn_delta.dy) * 41'(sn);
      pyc_q  <= 41'(sn_delta.dy) * 41'(cs);
      pxs_q  <= 41'(sn_delta.dx) * 41'(sn);
      tx_q   <= 34'(rx_d >>> 8);
      ty_q   <= 34'(ry_d >>> 8);
      vx_q   <= 36'((59'(tx_q) * 59'($signed({1'b0, scale_q}))) >>> 23);
      vy_q   <= 36'((59'(ty_q) * 59'($signed({1'b0, scale_q}))) >>> 23);
      vec4_q <= vec4_d;
      big4_q <= |hi_d;
      sqx_q  <= 48'(vec4_q.nx) * 48'(vec4_q.nx);
      sqy_q  <= 48'(vec4_q.ny) * 48'(vec4_q.ny);
      vec5_q <= vec4_q;
      big5_q <= big4_q;
      sum6_q <= sum_d;
      vec6_q <= vec6_d;
    end
  end

  mmp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (r6_vld_q),
    .n_i    (sum6_q),
    .vec_i  (vec6_q),
    .vld_o  (sq_vld),
    .root_o (root),
    .vec_o  (vec_sq)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      den7_q    <= (root == '0) ? 25'd1 : root;
      num7_q[0] <= 42'(vec_sq.nx) * 42'(rq);
      num7_q[1] <= 42'(vec_sq.ny) * 42'(rq);
      vec7_q    <= vec_sq;
    end
  end

  mmp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (r7_vld_q),
    .num_i  (num7_q),
    .den_i  (den7_q),
    .vec_i  (vec7_q),
    .vld_o  (dv_vld),
    .quo_o  (quo),
    .vec_o  (vec_dv)
  );

  // recenter, round half up, saturate
  assign base13 = $signed({3'b0, hs_q}) + 13'(off_q);

  always_comb begin
    mag[0] = vec_dv.outside ? 24'(quo[0]) : vec_dv.nx;
    mag[1] = vec_dv.outside ? 24'(quo[1]) : vec_dv.ny;
    sgn[0] = vec_dv.sx;
    sgn[1] = vec_dv.sy;
    for (int l = 0; l < 2; l++) begin
      vsel[l] = sgn[l] ? -$signed({1'b0, mag[l]}) : $signed({1'b0, mag[l]});
      pos[l]  = (27'(base13) <<< 8) + 27'(vsel[l]) + 27'sd128;
      rnd[l]  = 19'(pos[l] >>> 8);
      if (rnd[l] > 19'sd2047) begin
        sat[l] = 12'sd2047;
      end else if (rnd[l] < -19'sd2048) begin
        sat[l] = -12'sd2048;
      end else begin
        sat[l] = rnd[l][11:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mx_q    <= sat[0];
      my_q    <= sat[1];
      clamp_q <= vec_dv.outside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q  <= 1'b0;
      r2_vld_q  <= 1'b0;
      r3_vld_q  <= 1'b0;
      r4_vld_q  <= 1'b0;
      r5_vld_q  <= 1'b0;
      r6_vld_q  <= 1'b0;
      r7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      r1_vld_q  <= sn_vld;
      r2_vld_q  <= r1_vld_q;
      r3_vld_q  <= r2_vld_q;
      r4_vld_q  <= r3_vld_q;
      r5_vld_q  <= r4_vld_q;
      r6_vld_q  <= r5_vld_q;
      r7_vld_q  <= sq_vld;
      out_vld_q <= dv_vld;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = {my_q, mx_q};
  assign m_axis_tuser[0] = clamp_q;

  a_clamp_within_radius : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && vec_dv.outside) |-> (quo[0] <= rq && quo[1] <= rq))
    else $error("clamped magnitude exceeds radius");

  a_inside_within_radius : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && !vec_dv.outside) |-> (vec_dv.nx <= 24'(rq) && vec_dv.ny <= 24'(rq)))
    else $error("unclamped point lies beyond radius");

  a_stall_freezes_valids : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable({r1_vld_q, r2_vld_q, r3_vld_q, r4_vld_q, r5_vld_q, r6_vld_q,
                          r7_vld_q, out_vld_q}))
    else $error("stage valid changed during stall");

endmodule
